// ===== hw/rtl/spnq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spnq_pkg: shared types and codes of the shortest-process-next queue
// Request and response words, status codes, action codes and the sequencer
// state encoding.
// ----------------------------------------------------------------------------
package spnq_pkg;

   // Request word: one tick or one job to add
   typedef struct packed {
      logic        action;
      logic [15:0] burst_time;
   } spnq_req_type;

   // Response word: one per request
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] turnaround;
      logic [4:0]  queue_count;
      logic [15:0] front_remaining;
   } spnq_rsp_type;

   // Action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_ADD  = 1'b1;

   // Status codes
   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_IDLE_TICK = 3'd1,
      ST_RAN       = 3'd2,
      ST_FINISHED  = 3'd3,
      ST_REJ_FULL  = 3'd4,
      ST_REJ_ZERO  = 3'd5
   } spnq_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_CMP,
      S_ADD_PUT,
      S_TICK_RD,
      S_TICK_UPD,
      S_FRONT_RD,
      S_FRONT_GET
   } spnq_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/spnq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spnq_ram: job store of the shortest-process-next queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spnq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/shortest_process_next_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_process_next_queue: non-preemptive shortest-process-next scheduler
// Sorted job queue in a circular store, walked one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per event: a tick, or an add with its burst time.
//   rsp_* returns exactly one word per request: status, turnaround of a job
//   that just finished, queue count and remaining ticks of the front job.
//   Both channels move a word when valid is high and stall is low.
// Order of work:
//   A tick on a busy queue passes S_TICK_RD, S_TICK_UPD, S_FRONT_RD and
//   S_FRONT_GET; an idle tick or a rejected add passes S_FRONT_RD and
//   S_FRONT_GET. An accepted add walks down from the tail, one compare per
//   cycle, in S_ADD_RD and S_ADD_CMP (a front job that has run is never
//   passed; with no job to pass it goes straight on), then S_ADD_PUT,
//   S_FRONT_RD and S_FRONT_GET. The next request is taken in the cycle the
//   response turns valid, so a new request is not taken before the last is done.
//   req_stall is high while a word is in work.
// Reset:
//   Synchronous reset empties the queue and clears the time counter.
// Receiver stall:
//   The response sits in an output register; the next request is taken
//   meanwhile, and its response waits until the register is free.
// ----------------------------------------------------------------------------
module shortest_process_next_queue
   import spnq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int BURST_BITS  = 16,
   parameter int TIME_BITS   = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire spnq_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output spnq_rsp_type      rsp_data
);

   localparam int ADDR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS = BURST_BITS + TIME_BITS;

   typedef logic [BURST_BITS-1:0] burst_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   // Circular pointer steps
   function automatic addr_type ptr_inc(input addr_type p);
      return (p == addr_type'(QUEUE_DEPTH - 1)) ? '0 : p + addr_type'(1);
   endfunction

   function automatic addr_type ptr_dec(input addr_type p);
      return (p == '0) ? addr_type'(QUEUE_DEPTH - 1) : p - addr_type'(1);
   endfunction

   spnq_state_type  state_ff, state_in;
   cnt_type         count_ff, count_in;
   addr_type        head_ff, head_in;
   addr_type        tail_ff, tail_in;
   time_type        time_ff, time_in;
   logic            started_ff, started_in;
   logic            rsp_valid_ff, rsp_valid_in;
   burst_type       burst_ff, burst_in;
   addr_type        rd_ptr_ff, rd_ptr_in;
   addr_type        wr_ptr_ff, wr_ptr_in;
   cnt_type         left_ff, left_in;
   spnq_status_type status_ff, status_in;
   time_type        turn_ff, turn_in;
   spnq_rsp_type    rsp_data_ff, rsp_data_in;

   logic                  ram_we;
   addr_type              ram_waddr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   addr_type              ram_raddr;
   logic [ENTRY_BITS-1:0] ram_rdata;
   burst_type             rd_rem;
   time_type              rd_start;
   burst_type             rem_dec;

   spnq_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Split the stored entry into remaining time and start time
   assign rd_rem   = ram_rdata[ENTRY_BITS-1 -: BURST_BITS];
   assign rd_start = ram_rdata[TIME_BITS-1:0];
   assign rem_dec  = rd_rem - burst_type'(1);

   // Next state, datapath and store control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      time_in      = time_ff;
      started_in   = started_ff;
      burst_in     = burst_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      left_in      = left_ff;
      status_in    = status_ff;
      turn_in      = turn_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = wr_ptr_ff;
      ram_wdata    = {burst_ff, time_ff};
      ram_raddr    = rd_ptr_ff;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               burst_in = burst_type'(req_data.burst_time);
               turn_in  = '0;
               if (req_data.action == ACT_ADD) begin
                  if (burst_in == '0) begin
                     status_in = ST_REJ_ZERO;
                     state_in  = S_FRONT_RD;
                  end else if (count_ff == cnt_type'(QUEUE_DEPTH)) begin
                     status_in = ST_REJ_FULL;
                     state_in  = S_FRONT_RD;
                  end else begin
                     // walk down from the tail; a started front job stays put
                     status_in = ST_ADDED;
                     wr_ptr_in = tail_ff;
                     rd_ptr_in = ptr_dec(tail_ff);
                     left_in   = (started_ff && count_ff != '0) ?
                                 count_ff - cnt_type'(1) : count_ff;
                     state_in  = (left_in == '0) ? S_ADD_PUT : S_ADD_RD;
                  end
               end else begin
                  time_in = time_ff + time_type'(1);
                  if (count_ff == '0) begin
                     status_in = ST_IDLE_TICK;
                     state_in  = S_FRONT_RD;
                  end else begin
                     state_in = S_TICK_RD;
                  end
               end
            end
         end

         S_ADD_RD: begin
            ram_raddr = rd_ptr_ff;
            rd_ptr_in = ptr_dec(rd_ptr_ff);
            state_in  = S_ADD_CMP;
         end

         S_ADD_CMP: begin
            // read the next lower entry ahead while this one is compared
            ram_raddr = rd_ptr_ff;
            if (rd_rem > burst_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ptr_ff;
               ram_wdata = ram_rdata;
               wr_ptr_in = ptr_dec(wr_ptr_ff);
               rd_ptr_in = ptr_dec(rd_ptr_ff);
               left_in   = left_ff - cnt_type'(1);
               if (left_ff == cnt_type'(1)) begin
                  state_in = S_ADD_PUT;
               end
            end else begin
               state_in = S_ADD_PUT;
            end
         end

         S_ADD_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_ff;
            ram_wdata = {burst_ff, time_ff};
            tail_in   = ptr_inc(tail_ff);
            count_in  = count_ff + cnt_type'(1);
            state_in  = S_FRONT_RD;
         end

         S_TICK_RD: begin
            ram_raddr = head_ff;
            state_in  = S_TICK_UPD;
         end

         S_TICK_UPD: begin
            // run the front job one tick; drop it when done
            started_in = 1'b1;
            if (rem_dec == '0) begin
               turn_in    = time_ff - rd_start;
               head_in    = ptr_inc(head_ff);
               count_in   = count_ff - cnt_type'(1);
               started_in = 1'b0;
               status_in  = ST_FINISHED;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = head_ff;
               ram_wdata = {rem_dec, rd_start};
               status_in = ST_RAN;
            end
            state_in = S_FRONT_RD;
         end

         S_FRONT_RD: begin
            ram_raddr = head_ff;
            state_in  = S_FRONT_GET;
         end

         S_FRONT_GET: begin
            // keep the front entry on the read port while the output waits
            ram_raddr = head_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.turnaround      = 32'(turn_ff);
               rsp_data_in.queue_count     = 5'(count_ff);
               rsp_data_in.front_remaining = (count_ff != '0) ? 16'(rd_rem) : 16'd0;
               state_in                    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         time_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         time_ff      <= time_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      burst_ff    <= burst_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      left_ff     <= left_in;
      status_ff   <= status_in;
      turn_ff     <= turn_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Queue never holds more jobs than it has entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= QUEUE_DEPTH)
      else $error("queue count exceeds depth");

   // Tail pointer stays head plus count around the ring
   a_tail_track: assert property (@(posedge clock) disable iff (reset)
      (int'(head_ff) + int'(count_ff) == int'(tail_ff)) ||
      (int'(head_ff) + int'(count_ff) == int'(tail_ff) + QUEUE_DEPTH))
      else $error("tail pointer out of step with head and count");

   // A started front job exists in the queue
   a_started_job: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (count_ff != '0))
      else $error("front marked started on empty queue");

   // Turnaround is reported only for a finished job
   a_turn_only_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == ST_FINISHED ||
                        rsp_data_ff.turnaround == 32'd0))
      else $error("turnaround on non-finish response");

endmodule
`default_nettype wire
